FILE: rtl/core/wsfp_pkg.sv
// package for the websocket frame parser
// holds the parse phase type, field widths and the result record
// no dependencies
`default_nettype none
package wsfp_pkg;

  localparam int unsigned LEN_W = 63;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [2:0] EXT16_BYTES = 3'd2;
  localparam logic [2:0] EXT64_BYTES = 3'd0;  // eight bytes, index wraps to zero
  localparam logic [2:0] KEY_LAST_IDX = 3'd3;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_LENMASK = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_CONTENT = 3'd4
  } wsfp_phase_t;

  typedef struct packed {
    logic             kind;
    logic             fin;
    logic [2:0]       rsv;
    logic [3:0]       opcode;
    logic             masked;
    logic [LEN_W-1:0] payload_length;
    logic [7:0]       payload_byte;
    logic             last;
  } wsfp_result_t;

endpackage
`default_nettype wire

FILE: rtl/core/wsfp_if.sv
// valid/ready channel interfaces for the websocket frame parser
// depends on wsfp_pkg for the length width
`default_nettype none
interface wsfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface wsfp_out_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic                      fin;
  logic [2:0]                rsv;
  logic [3:0]                opcode;
  logic                      masked;
  logic [wsfp_pkg::LEN_W-1:0] payload_length;
  logic [7:0]                payload_byte;
  logic                      last;

  modport source (output valid, output kind, output fin, output rsv, output opcode,
                  output masked, output payload_length, output payload_byte,
                  output last, input ready);
  modport sink (input valid, input kind, input fin, input rsv, input opcode,
                input masked, input payload_length, input payload_byte,
                input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/websocket_frame_parser_unit.sv
// websocket frame parser top: one byte per cycle in unless stalled; header, payload results out
// output: a result is registered and appears in the cycle after the byte that causes it is accepted
// throughput: one byte per cycle unless a result waits and the output is not ready that cycle
// reset: synchronous active-low rst_n returns to the header phase with an empty output register
// depends on wsfp_pkg, wsfp_if and wsfp_core
`default_nettype none
module websocket_frame_parser_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  wsfp_in_if.sink    in_chan,
  wsfp_out_if.source out_chan
);
  import wsfp_pkg::*;

  logic         out_valid_r;
  wsfp_result_t out_data_r;
  logic         accept;
  logic         emit;
  wsfp_result_t res;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  wsfp_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (accept),
    .byte_i (in_chan.data_byte),
    .emit_o (emit),
    .res_o  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_data_r <= res;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.kind           = out_data_r.kind;
  assign out_chan.fin            = out_data_r.fin;
  assign out_chan.rsv            = out_data_r.rsv;
  assign out_chan.opcode         = out_data_r.opcode;
  assign out_chan.masked         = out_data_r.masked;
  assign out_chan.payload_length = out_data_r.payload_length;
  assign out_chan.payload_byte   = out_data_r.payload_byte;
  assign out_chan.last           = out_data_r.last;

endmodule
`default_nettype wire

FILE: rtl/core/wsfp_core.sv
// frame parse state and per-byte step logic
// depends on wsfp_pkg; produces at most one result per accepted byte
`default_nettype none
module wsfp_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step_i,
  input  wire logic [7:0]            byte_i,
  output logic                       emit_o,
  output wsfp_pkg::wsfp_result_t     res_o
);
  import wsfp_pkg::*;

  wsfp_phase_t      phase_r, phase_nxt;
  logic [7:0]       hdr_r, hdr_nxt;
  logic             mask_r, mask_nxt;
  logic [6:0]       code_r, code_nxt;
  logic [2:0]       idx_r, idx_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [31:0]      key_r, key_nxt;
  logic [LEN_W-1:0] left_r, left_nxt;
  logic [1:0]       kidx_r, kidx_nxt;

  logic             finish_len;
  logic             emit;
  logic             res_kind;
  logic [7:0]       res_byte;
  logic             res_last;
  logic [7:0]       key_byte;
  logic [LEN_W-1:0] left_dec;
  logic [2:0]       need;

  always_comb begin
    unique case (kidx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  assign need     = (code_r == LEN_CODE_16) ? EXT16_BYTES : EXT64_BYTES;
  assign left_dec = (left_r != '0) ? left_r - LEN_W'(1) : left_r;

  always_comb begin
    phase_nxt  = phase_r;
    hdr_nxt    = hdr_r;
    mask_nxt   = mask_r;
    code_nxt   = code_r;
    idx_nxt    = idx_r;
    len_nxt    = len_r;
    key_nxt    = key_r;
    left_nxt   = left_r;
    kidx_nxt   = kidx_r;
    finish_len = 1'b0;
    emit       = 1'b0;
    res_kind   = KIND_HEADER;
    res_byte   = 8'd0;
    res_last   = 1'b0;

    unique case (phase_r)
      PH_LENMASK: begin
        mask_nxt = byte_i[7];
        code_nxt = byte_i[6:0];
        idx_nxt  = 3'd0;
        if (byte_i[6:0] < LEN_CODE_16) begin
          len_nxt    = {{(LEN_W-7){1'b0}}, byte_i[6:0]};
          finish_len = 1'b1;
        end else begin
          len_nxt   = '0;
          phase_nxt = PH_EXTLEN;
        end
      end
      PH_EXTLEN: begin
        len_nxt = {len_r[LEN_W-9:0], byte_i};
        idx_nxt = idx_r + 3'd1;
        if (idx_nxt == need) begin
          finish_len = 1'b1;
        end
      end
      PH_MASK: begin
        key_nxt = {key_r[23:0], byte_i};
        idx_nxt = idx_r + 3'd1;
        if (idx_r == KEY_LAST_IDX) begin
          idx_nxt   = 3'd0;
          kidx_nxt  = 2'd0;
          left_nxt  = len_r;
          emit      = 1'b1;
          res_last  = (len_r == '0);
          phase_nxt = (len_r == '0) ? PH_HEADER : PH_CONTENT;
        end
      end
      PH_CONTENT: begin
        res_byte = byte_i ^ (mask_r ? key_byte : 8'd0);
        if (mask_r) begin
          kidx_nxt = kidx_r + 2'd1;
        end
        left_nxt = left_dec;
        emit     = 1'b1;
        res_kind = KIND_PAYLOAD;
        res_last = (left_dec == '0);
        if (left_dec == '0) begin
          phase_nxt = PH_HEADER;
        end
      end
      default: begin
        hdr_nxt   = byte_i;
        mask_nxt  = 1'b0;
        code_nxt  = 7'd0;
        idx_nxt   = 3'd0;
        len_nxt   = '0;
        key_nxt   = 32'd0;
        left_nxt  = '0;
        kidx_nxt  = 2'd0;
        phase_nxt = PH_LENMASK;
      end
    endcase

    if (finish_len) begin
      key_nxt = 32'd0;
      if (mask_nxt) begin
        phase_nxt = PH_MASK;
        idx_nxt   = 3'd0;
      end else begin
        kidx_nxt  = 2'd0;
        left_nxt  = len_nxt;
        emit      = 1'b1;
        res_last  = (len_nxt == '0);
        phase_nxt = (len_nxt == '0) ? PH_HEADER : PH_CONTENT;
      end
    end
  end

  always_comb begin
    emit_o               = emit;
    res_o.kind           = res_kind;
    res_o.fin            = hdr_nxt[7];
    res_o.rsv            = hdr_nxt[6:4];
    res_o.opcode         = hdr_nxt[3:0];
    res_o.masked         = mask_nxt;
    res_o.payload_length = len_nxt;
    res_o.payload_byte   = res_byte;
    res_o.last           = res_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hdr_r   <= 8'd0;
      mask_r  <= 1'b0;
      code_r  <= 7'd0;
      idx_r   <= 3'd0;
      len_r   <= '0;
      key_r   <= 32'd0;
      left_r  <= '0;
      kidx_r  <= 2'd0;
    end else if (step_i) begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      mask_r  <= mask_nxt;
      code_r  <= code_nxt;
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
      key_r   <= key_nxt;
      left_r  <= left_nxt;
      kidx_r  <= kidx_nxt;
    end
  end

endmodule
`default_nettype wire
